/* rtl/qrs_pkg.sv */
// Shared constants for the quadratic root solver.
// No dependencies; used by every module of the block.
`default_nettype none
package qrs_pkg;
  localparam int COEF_BITS_DEF      = 16;
  localparam int ROOT_FRAC_BITS_DEF = 16;
  localparam int ROOT_BITS          = 32;
  localparam int QUEUE_DEPTH        = 4;
endpackage
`default_nettype wire

/* rtl/qrs_front.sv */
// Front end: input capture, coefficient products, discriminant and case split.
// Depends on qrs_pkg only for defaults; emits one packed work item per transaction.
`default_nettype none
module qrs_front #(
  parameter int COEF_BITS      = qrs_pkg::COEF_BITS_DEF,
  parameter int ROOT_FRAC_BITS = qrs_pkg::ROOT_FRAC_BITS_DEF,
  localparam int DW   = 2 * COEF_BITS + 2,
  localparam int NUMW = COEF_BITS + ROOT_FRAC_BITS + 2,
  localparam int DENW = COEF_BITS + 1,
  localparam int IW   = 1 + DW + NUMW + DENW
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [COEF_BITS-1:0] in_coef_a,
  input  wire logic signed [COEF_BITS-1:0] in_coef_b,
  input  wire logic signed [COEF_BITS-1:0] in_coef_c,
  output logic                             push_vld,
  input  wire logic                        push_full,
  output logic [IW-1:0]                    push_item
);
  localparam int PW = 2 * COEF_BITS;
  localparam int SDW = DW + 1;

  logic                        f1_vld_r;
  logic signed [COEF_BITS-1:0] f1_a_r, f1_b_r, f1_c_r;
  logic                        f2_vld_r;
  logic signed [COEF_BITS-1:0] f2_a_r, f2_b_r, f2_c_r;
  logic signed [PW-1:0]        f2_q_r, f2_p_r;
  logic                        front_adv, f1_load;

  assign front_adv = !push_full || !f2_vld_r;
  assign f1_load   = front_adv || !f1_vld_r;
  assign in_stall  = !f1_load;
  assign push_vld  = f2_vld_r && !push_full;

  // stage 1: capture; stage 2: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else begin
      if (f1_load) f1_vld_r <= in_valid;
      if (front_adv) f2_vld_r <= f1_vld_r;
    end
    if (f1_load) begin
      f1_a_r <= in_coef_a;
      f1_b_r <= in_coef_b;
      f1_c_r <= in_coef_c;
    end
    if (front_adv) begin
      f2_a_r <= f1_a_r;
      f2_b_r <= f1_b_r;
      f2_c_r <= f1_c_r;
      f2_q_r <= f1_b_r * f1_b_r;
      f2_p_r <= f1_a_r * f1_c_r;
    end
  end

  // discriminant and classification
  logic signed [SDW-1:0]  disc;
  logic                   found;
  logic [DW-1:0]          d_out;
  logic signed [NUMW-1:0] nb;
  logic signed [DENW-1:0] den;

  always_comb begin
    disc  = SDW'(f2_q_r) - (SDW'(f2_p_r) <<< 2);
    found = 1'b0;
    d_out = '0;
    nb    = '0;
    den   = '0;
    if (f2_a_r == '0) begin
      // linear case: -c / b
      found = (f2_b_r != '0);
      nb    = -(NUMW'(f2_c_r) <<< ROOT_FRAC_BITS);
      den   = DENW'(f2_b_r);
    end else begin
      found = !disc[SDW-1];
      d_out = found ? disc[DW-1:0] : '0;
      nb    = -(NUMW'(f2_b_r) <<< ROOT_FRAC_BITS);
      den   = DENW'(f2_a_r) <<< 1;
    end
    push_item = {found, d_out, nb, den};
  end
endmodule
`default_nettype wire

/* rtl/qrs_queue.sv */
// Short queue between front and back ends.
// Generic width; no package dependencies beyond the depth default.
`default_nettype none
module qrs_queue #(
  parameter int W     = 8,
  parameter int DEPTH = qrs_pkg::QUEUE_DEPTH,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              pop_vld,
  output logic [W-1:0]      pop_data
);
  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign pop_data = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop && pop_vld) rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop && pop_vld);
    end
    if (push) mem[wr_r] <= push_data;
  end
endmodule
`default_nettype wire

/* rtl/qrs_back.sv */
// Back end: bit-per-stage square root, two bit-per-stage dividers, clamp.
// Consumes packed items from the queue; depends on qrs_pkg for output width.
`default_nettype none
module qrs_back #(
  parameter int COEF_BITS      = qrs_pkg::COEF_BITS_DEF,
  parameter int ROOT_FRAC_BITS = qrs_pkg::ROOT_FRAC_BITS_DEF,
  localparam int DW   = 2 * COEF_BITS + 2,
  localparam int NUMW = COEF_BITS + ROOT_FRAC_BITS + 2,
  localparam int DENW = COEF_BITS + 1,
  localparam int IW   = 1 + DW + NUMW + DENW
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               item_vld,
  input  wire logic [IW-1:0]                      item,
  output logic                                    item_pop,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_found,
  output logic signed [qrs_pkg::ROOT_BITS-1:0]    out_root_one,
  output logic signed [qrs_pkg::ROOT_BITS-1:0]    out_root_two,
  output logic                                    out_saturated
);
  localparam int SW = COEF_BITS + ROOT_FRAC_BITS + 1;
  localparam int NW = 2 * SW;
  localparam int RW = SW + 3;
  localparam int MW = COEF_BITS + ROOT_FRAC_BITS + 1;
  localparam int OB = qrs_pkg::ROOT_BITS;
  localparam int CW = (MW > OB) ? MW + 1 : OB + 1;

  typedef struct packed {
    logic                   vld;
    logic                   found;
    logic signed [NUMW-1:0] nb;
    logic signed [DENW-1:0] den;
    logic [RW-1:0]          rem;
    logic [SW-1:0]          root;
    logic [NW-1:0]          nsh;
  } sq_t;

  typedef struct packed {
    logic          neg;
    logic [MW-1:0] qn;
    logic [DENW:0] rem;
  } lane_t;

  typedef struct packed {
    logic            vld;
    logic            found;
    logic [DENW-1:0] dmag;
    lane_t           l1;
    lane_t           l2;
  } dv_t;

  // one square root bit
  function automatic sq_t sq_step(input sq_t s);
    sq_t           o;
    logic [RW-1:0] remx, trial;
    logic          ge;
    o     = s;
    remx  = {s.rem[RW-3:0], s.nsh[NW-1:NW-2]};
    trial = {1'b0, s.root, 2'b01};
    ge    = (remx >= trial);
    o.rem  = ge ? remx - trial : remx;
    o.root = {s.root[SW-2:0], ge};
    o.nsh  = {s.nsh[NW-3:0], 2'b00};
    return o;
  endfunction

  // one quotient bit
  function automatic lane_t dv_step(input lane_t l, input logic [DENW-1:0] dmag);
    lane_t         o;
    logic [DENW:0] remx;
    logic          ge;
    o    = l;
    remx = {l.rem[DENW-1:0], l.qn[MW-1]};
    ge   = (remx >= {1'b0, dmag});
    o.rem = ge ? remx - {1'b0, dmag} : remx;
    o.qn  = {l.qn[MW-2:0], ge};
    return o;
  endfunction

  // divider lane setup from a signed numerator
  function automatic lane_t lane_init(input logic signed [NUMW-1:0] n,
                                      input logic den_neg);
    lane_t                  o;
    logic signed [NUMW-1:0] m;
    m      = n[NUMW-1] ? -n : n;
    o.neg  = n[NUMW-1] ^ den_neg;
    o.qn   = m[MW-1:0];
    o.rem  = '0;
    return o;
  endfunction

  // sign and clamp to the output range
  function automatic logic [OB:0] clamp(input lane_t l);
    logic [CW-1:0] qz;
    logic [OB-1:0] v;
    logic          sat;
    qz  = CW'(l.qn);
    sat = 1'b0;
    if (l.neg) begin
      if (qz > (CW'(1) << (OB - 1))) begin
        sat = 1'b1;
        v   = {1'b1, {(OB-1){1'b0}}};
      end else begin
        v = ~qz[OB-1:0] + 1'b1;
      end
    end else begin
      if (qz > ((CW'(1) << (OB - 1)) - 1'b1)) begin
        sat = 1'b1;
        v   = {1'b0, {(OB-1){1'b1}}};
      end else begin
        v = qz[OB-1:0];
      end
    end
    return {sat, v};
  endfunction

  sq_t   sq_r [SW+1];
  dv_t   dv_r [MW+1];
  logic  adv;
  sq_t   sq_in;
  dv_t   dv_in;
  sq_t   sq_last;
  logic signed [NUMW-1:0] s_ext;
  logic [OB:0] c1, c2;

  assign adv      = !out_valid || !out_stall;
  assign item_pop = adv && item_vld;

  // unpack the queued item
  always_comb begin
    sq_in.vld   = item_vld;
    sq_in.found = item[IW-1];
    sq_in.nsh   = {item[IW-2 -: DW], {(2*ROOT_FRAC_BITS){1'b0}}};
    sq_in.nb    = item[DENW +: NUMW];
    sq_in.den   = item[DENW-1:0];
    sq_in.rem   = '0;
    sq_in.root  = '0;
  end

  // root done: set up both dividers
  always_comb begin
    sq_last     = sq_r[SW];
    s_ext       = signed'({1'b0, sq_last.root});
    dv_in.vld   = sq_last.vld;
    dv_in.found = sq_last.found;
    dv_in.dmag  = sq_last.den[DENW-1] ? DENW'(-sq_last.den) : DENW'(sq_last.den);
    dv_in.l1    = lane_init(sq_last.nb + s_ext, sq_last.den[DENW-1]);
    dv_in.l2    = lane_init(sq_last.nb - s_ext, sq_last.den[DENW-1]);
    c1          = clamp(dv_r[MW].l1);
    c2          = clamp(dv_r[MW].l2);
  end

  // pipeline advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SW; k++) sq_r[k].vld <= 1'b0;
      for (int k = 0; k <= MW; k++) dv_r[k].vld <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      sq_r[0] <= sq_in;
      for (int k = 0; k < SW; k++) sq_r[k+1] <= sq_step(sq_r[k]);
      dv_r[0] <= dv_in;
      for (int k = 0; k < MW; k++) begin
        dv_r[k+1].vld   <= dv_r[k].vld;
        dv_r[k+1].found <= dv_r[k].found;
        dv_r[k+1].dmag  <= dv_r[k].dmag;
        dv_r[k+1].l1    <= dv_step(dv_r[k].l1, dv_r[k].dmag);
        dv_r[k+1].l2    <= dv_step(dv_r[k].l2, dv_r[k].dmag);
      end
      out_valid <= dv_r[MW].vld;
    end
    if (adv) begin
      out_found     <= dv_r[MW].found;
      out_root_one  <= dv_r[MW].found ? c1[OB-1:0] : '0;
      out_root_two  <= dv_r[MW].found ? c2[OB-1:0] : '0;
      out_saturated <= dv_r[MW].found && (c1[OB] || c2[OB]);
    end
  end
endmodule
`default_nettype wire

/* rtl/quadratic_root_solver_top.sv */
// Top level of the quadratic root solver: front end, queue, back end.
// Depends on qrs_pkg, qrs_front, qrs_queue and qrs_back.
`default_nettype none
// Real roots of a*x^2+b*x+c=0 for signed coefficients with 8 fraction bits.
// One transaction is accepted per cycle and one result leaves per cycle,
// fully pipelined, unless out_stall or a full queue holds the flow. The
// accepting edge loads the capture stage; then come the products stage, the
// queue entry, the square-root input register, COEF_BITS+ROOT_FRAC_BITS+1
// square-root stages at one root bit each, the divider input register, as
// many divider stages at one quotient bit each, and the clamp register. A
// four-entry queue decouples the front end from the back end, so out_stall
// reaches in_stall only after the queue fills.
module quadratic_root_solver_top #(
  parameter int COEF_BITS      = qrs_pkg::COEF_BITS_DEF,
  parameter int ROOT_FRAC_BITS = qrs_pkg::ROOT_FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [COEF_BITS-1:0]      in_coef_a,
  input  wire logic signed [COEF_BITS-1:0]      in_coef_b,
  input  wire logic signed [COEF_BITS-1:0]      in_coef_c,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_found,
  output logic signed [qrs_pkg::ROOT_BITS-1:0]  out_root_one,
  output logic signed [qrs_pkg::ROOT_BITS-1:0]  out_root_two,
  output logic                                  out_saturated
);
  localparam int IW = 1 + (2 * COEF_BITS + 2) + (COEF_BITS + ROOT_FRAC_BITS + 2)
                      + (COEF_BITS + 1);

  logic          push_vld, q_full, q_vld, q_pop;
  logic [IW-1:0] push_item, q_item;

  qrs_front #(.COEF_BITS(COEF_BITS), .ROOT_FRAC_BITS(ROOT_FRAC_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_coef_a, .in_coef_b, .in_coef_c,
    .push_vld, .push_full(q_full), .push_item
  );

  qrs_queue #(.W(IW), .DEPTH(qrs_pkg::QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(push_vld), .push_data(push_item), .full(q_full),
    .pop(q_pop), .pop_vld(q_vld), .pop_data(q_item)
  );

  qrs_back #(.COEF_BITS(COEF_BITS), .ROOT_FRAC_BITS(ROOT_FRAC_BITS)) u_back (
    .clk, .rst_n, .item_vld(q_vld), .item(q_item), .item_pop(q_pop),
    .out_valid, .out_stall, .out_found, .out_root_one, .out_root_two,
    .out_saturated
  );
endmodule
`default_nettype wire

/* rtl/qrs_checker.sv */
// Port-level checks for the quadratic root solver, bound to the top level.
// Depends on qrs_pkg for the root width.
`default_nettype none
module qrs_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            out_found,
  input wire logic [qrs_pkg::ROOT_BITS-1:0]   out_root_one,
  input wire logic [qrs_pkg::ROOT_BITS-1:0]   out_root_two,
  input wire logic                            out_saturated
);
  // a stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_root_one)
      && $stable(out_root_two) && $stable(out_found) && $stable(out_saturated))
    else $error("stalled result changed");

  // no root means zero roots and no clamp
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_root_one == '0 && out_root_two == '0
      && !out_saturated)
    else $error("result without root not cleared");

  // clamp only on a found root
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_found)
    else $error("saturation without root");
endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_found, .out_root_one,
  .out_root_two, .out_saturated
);
`default_nettype wire

/* tb/quadratic_root_solver_top_tb.sv */
// Self-checking testbench for quadratic_root_solver_top.
// Depends on qrs_pkg and the solver RTL; predicts each result in-line and
// checks every result transaction in order under random stalls and gaps.
`default_nettype none
module quadratic_root_solver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB         = qrs_pkg::COEF_BITS_DEF;
  localparam int FB         = qrs_pkg::ROOT_FRAC_BITS_DEF;
  localparam int RB         = qrs_pkg::ROOT_BITS;
  localparam int DRAIN      = 2 * CB + 2 * FB + 7 + qrs_pkg::QUEUE_DEPTH + 30;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic          found;
    logic [RB-1:0] root_one;
    logic [RB-1:0] root_two;
    logic          saturated;
  } roots_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [CB-1:0] in_coef_a = '0;
  logic signed [CB-1:0] in_coef_b = '0;
  logic signed [CB-1:0] in_coef_c = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  logic                 out_found;
  logic signed [RB-1:0] out_root_one;
  logic signed [RB-1:0] out_root_two;
  logic                 out_saturated;

  roots_t pending_roots[$];
  int     err_cnt = 0;
  int     sent_cnt = 0;
  int     checked_cnt = 0;
  int     found_cnt = 0;
  int     sat_cnt = 0;
  int     cycle_cnt = 0;
  int     hold_cycles = 0;
  bit     no_idle = 1'b0;

  quadratic_root_solver_top dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_coef_a, .in_coef_b, .in_coef_c,
    .out_valid, .out_stall, .out_found, .out_root_one, .out_root_two,
    .out_saturated
  );

  always #6 clk = ~clk;

  // Integer square root of a 128-bit value, one bit per step
  function automatic logic [63:0] isqrt(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  // Truncating divide with clamp to signed 32 bits
  function automatic logic [RB-1:0] div_clamp(input longint num, input longint den,
                                              inout logic sat);
    longint unsigned q;
    longint unsigned mn;
    longint unsigned md;
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    q = mn / md;
    if ((num < 0) != (den < 0)) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return 32'(q);
  endfunction

  // Expected roots for one coefficient set
  function automatic roots_t solve_roots(input logic signed [CB-1:0] ca,
                                         input logic signed [CB-1:0] cb,
                                         input logic signed [CB-1:0] cc);
    roots_t r;
    longint a, b, c, disc, nb;
    logic [63:0] s;
    a = ca; b = cb; c = cc;
    r = '0;
    if (a == 0) begin
      if (b != 0) begin
        r.found = 1'b1;
        r.root_one = div_clamp(-c * (64'sd1 <<< FB), b, r.saturated);
        r.root_two = r.root_one;
      end
    end else begin
      disc = b * b - 4 * a * c;
      if (disc >= 0) begin
        s = isqrt({64'd0, disc} << (2 * FB));
        nb = -b * (64'sd1 <<< FB);
        r.found = 1'b1;
        r.root_one = div_clamp(nb + longint'(s), 2 * a, r.saturated);
        r.root_two = div_clamp(nb - longint'(s), 2 * a, r.saturated);
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one transaction, wait for acceptance, then idle for a random gap
  task automatic send_coef(input logic [CB-1:0] a, input logic [CB-1:0] b,
                           input logic [CB-1:0] c);
    int gap;
    in_valid  <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    do @(posedge clk); while (in_stall);
    pending_roots.push_back(solve_roots(a, b, c));
    sent_cnt++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  // Result receiver stall pattern, with an optional long hold
  initial begin
    int run;
    run = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else if (run > 0) begin
        run--;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        run = pick_gap();
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    roots_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_roots.size() == 0) begin
        $error("result transaction with nothing expected");
        err_cnt++;
      end else begin
        exp_r = pending_roots.pop_front();
        checked_cnt++;
        found_cnt += exp_r.found;
        sat_cnt += exp_r.saturated;
        if (out_found !== exp_r.found) begin
          $error("found: expected %0d actual %0d", exp_r.found, out_found);
          err_cnt++;
        end
        if (out_root_one !== exp_r.root_one) begin
          $error("root_one: expected %h actual %h", exp_r.root_one, out_root_one);
          err_cnt++;
        end
        if (out_root_two !== exp_r.root_two) begin
          $error("root_two: expected %h actual %h", exp_r.root_two, out_root_two);
          err_cnt++;
        end
        if (out_saturated !== exp_r.saturated) begin
          $error("saturated: expected %0d actual %0d", exp_r.saturated, out_saturated);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("quadratic_root_solver_top_tb: FAIL");
      $finish;
    end
  end

  // Extremes and named corner cases
  task automatic test_directed();
    send_coef(16'h0000, 16'h0000, 16'h0000);   // a, b zero, c zero
    send_coef(16'h0000, 16'h0000, 16'h7FFF);   // a, b zero
    send_coef(16'h0000, 16'h0100, 16'h0200);   // linear
    send_coef(16'h0000, 16'h0001, 16'h7FFF);   // linear, large negative root
    send_coef(16'h0000, 16'h0001, 16'h8000);   // linear, clamp high (2^31)
    send_coef(16'h0000, 16'hFFFF, 16'h8000);   // linear, exactly -2^31
    send_coef(16'h0000, 16'h8000, 16'h7FFF);
    send_coef(16'h0100, 16'h0000, 16'h0100);   // negative discriminant
    send_coef(16'h0100, 16'h0200, 16'h0100);   // double root
    send_coef(16'hFF00, 16'h0200, 16'hFF00);   // double root, a negative
    send_coef(16'h0100, 16'h0000, 16'hFF00);   // roots +-1
    send_coef(16'h0100, 16'hFD00, 16'h0200);   // roots 1, 2
    send_coef(16'h0001, 16'h7FFF, 16'h0000);   // huge root
    send_coef(16'h0001, 16'h8000, 16'h8000);
    send_coef(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_coef(16'h8000, 16'h8000, 16'h8000);
    send_coef(16'h8000, 16'h7FFF, 16'h7FFF);
    send_coef(16'h7FFF, 16'h8000, 16'h8000);
    send_coef(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_coef(16'h0001, 16'h0000, 16'h8000);
    send_coef(16'h8000, 16'h0000, 16'h7FFF);
    send_coef(16'h0100, 16'h0000, 16'h0000);   // zero root
  endtask

  // Mixed random coefficient sets
  task automatic test_random(input int count);
    int kind, r1, r2;
    logic [CB-1:0] a, b, c;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      a = CB'($urandom); b = CB'($urandom); c = CB'($urandom);
      if (kind < 3) begin
        // small a, small c: mostly real roots
        a = CB'($signed($urandom_range(0, 1024)) - 512);
        c = CB'($signed($urandom_range(0, 4096)) - 2048);
      end else if (kind == 3) begin
        a = '0;
      end else if (kind == 4) begin
        // integer roots, exact discriminant
        r1 = $signed($urandom_range(0, 20)) - 10;
        r2 = $signed($urandom_range(0, 20)) - 10;
        a = 16'h0100;
        b = CB'(-(r1 + r2) * 256);
        c = CB'(r1 * r2 * 256);
      end
      send_coef(a, b, c);
    end
  endtask

  // Long receiver hold while the sender keeps offering; more items than
  // the pipeline and queue hold, so the input stalls
  task automatic test_backpressure();
    hold_cycles = 300;
    no_idle = 1'b1;
    test_random(150);
    no_idle = 1'b0;
  endtask

  // Back-to-back stream with no idling on either side
  task automatic test_streaming();
    no_idle = 1'b1;
    test_random(100);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_empty();          // sender pauses until all results are back
    test_random(300);
    test_backpressure();
    test_streaming();
    wait_empty();
    test_random(230);
    wait_empty();
    repeat (DRAIN) @(posedge clk);
    $display("sent %0d coefficient sets, checked %0d results", sent_cnt, checked_cnt);
    $display("%0d with roots found, %0d with clamped roots", found_cnt, sat_cnt);
    if (err_cnt == 0 && pending_roots.size() == 0) begin
      $display("quadratic_root_solver_top_tb: PASS");
    end else begin
      $display("quadratic_root_solver_top_tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
